### src/icau_pkg.sv
// Shared constants and types of the interval capacity admission unit.
`timescale 1ns / 1ps

package icau_pkg;

	// Number of locations in the occupancy store
	localparam int LOCATIONS = 1024;

	// Store index and walk counter widths
	localparam int LOC_W = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;
	localparam int CNT_W = $clog2(LOCATIONS + 1);

	// Fixed field widths
	localparam int PAX_W  = 8;
	localparam int SLOC_W = 10;
	localparam int ELOC_W = 11;
	localparam int CAP_W  = 20;
	localparam int OCC_W  = 21;

	// Common width for range compares against the store size
	localparam int CMP_W = (CNT_W > ELOC_W) ? CNT_W : ELOC_W;

	// Saturation limit of one occupancy entry
	localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

### src/interval_capacity_admission_unit.sv
// Top level of the interval capacity admission unit.
`timescale 1ns / 1ps

// Admission check for sets of interval reservations. Each input transaction is one
// trip (passengers, start_loc, end_loc exclusive, last_trip); the unit adds the
// passenger count to every covered location of an on-chip occupancy memory, walking
// the range one location per cycle through a read-modify-write loop on a single
// memory with a registered read. The first location above the capacity register
// raises a sticky failure; later trips of the set are skipped. Each trip yields one
// result transaction with fits and set_done. After reset and after every trip
// marked last, a clearing pass zeroes the memory, during which no trip is accepted;
// capacity writes are taken at all times. A new trip is accepted while the previous
// result still waits in the output register.
module interval_capacity_admission_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [icau_pkg::CAP_W-1:0]      cfg_capacity,
	// trip input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [icau_pkg::PAX_W-1:0]      passengers,
	input  logic [icau_pkg::SLOC_W-1:0]     start_loc,
	input  logic [icau_pkg::ELOC_W-1:0]     end_loc,
	input  logic                            last_trip,
	// verdict output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            fits,
	output logic                            set_done
);

	icau_pkg::state_t state_q;

	logic [icau_pkg::CAP_W-1:0] cap_q;
	logic                       ovf_q;
	logic [icau_pkg::LOC_W-1:0] clr_q;
	logic [icau_pkg::CNT_W-1:0] addr_q;
	logic [icau_pkg::CNT_W-1:0] hi_q;
	logic [icau_pkg::PAX_W-1:0] pax_q;
	logic                       last_q;

	logic                       rd_vld_s1;
	logic [icau_pkg::LOC_W-1:0] rd_addr_s1;
	logic [icau_pkg::OCC_W-1:0] rd_data_s1;

	logic                       out_valid_q;
	logic                       fits_q;
	logic                       set_done_q;

	// occupancy memory
	logic [icau_pkg::OCC_W-1:0] occ_mem [icau_pkg::LOCATIONS];

	logic [icau_pkg::CMP_W-1:0] lo_cmp;
	logic [icau_pkg::CMP_W-1:0] end_cmp;
	logic [icau_pkg::CMP_W-1:0] hi_cmp;
	logic                       trip_empty;
	logic                       in_acc;

	logic [icau_pkg::OCC_W:0]   sum_w;
	logic [icau_pkg::OCC_W-1:0] sum_sat;
	logic                       over;
	logic                       issue;

	logic                       mem_we;
	logic [icau_pkg::LOC_W-1:0] mem_waddr;
	logic [icau_pkg::OCC_W-1:0] mem_wdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == icau_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign fits      = fits_q;
	assign set_done  = set_done_q;

	// clamp the trip range to the store
	always_comb begin
		lo_cmp     = icau_pkg::CMP_W'(start_loc);
		end_cmp    = icau_pkg::CMP_W'(end_loc);
		hi_cmp     = (end_cmp > icau_pkg::CMP_W'(icau_pkg::LOCATIONS)) ?
		             icau_pkg::CMP_W'(icau_pkg::LOCATIONS) : end_cmp;
		trip_empty = ovf_q || (lo_cmp >= hi_cmp);
	end

	// add the count to the entry read last cycle, saturate, check capacity
	always_comb begin
		sum_w   = (icau_pkg::OCC_W + 1)'(rd_data_s1) + (icau_pkg::OCC_W + 1)'(pax_q);
		sum_sat = (sum_w > (icau_pkg::OCC_W + 1)'(icau_pkg::OCC_MAX)) ?
		          icau_pkg::OCC_MAX : sum_w[icau_pkg::OCC_W-1:0];
		over    = rd_vld_s1 && (sum_sat > icau_pkg::OCC_W'(cap_q));
		issue   = (state_q == icau_pkg::ST_WALK) && (addr_q != hi_q) && !over;
	end

	// select the memory write: zero during the clearing pass, the sum during a walk
	always_comb begin
		if (state_q == icau_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = rd_vld_s1 && (state_q == icau_pkg::ST_WALK);
			mem_waddr = rd_addr_s1;
			mem_wdata = sum_sat;
		end
	end

	// memory ports: one registered read, one write
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= occ_mem[addr_q[icau_pkg::LOC_W-1:0]];
		end
		if (mem_we) begin
			occ_mem[mem_waddr] <= mem_wdata;
		end
	end

	// hold trip payload and read address
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pax_q  <= passengers;
			last_q <= last_trip;
		end
		if (issue) begin
			rd_addr_s1 <= addr_q[icau_pkg::LOC_W-1:0];
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_capacity;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= icau_pkg::ST_CLEAR;
			clr_q       <= '0;
			ovf_q       <= 1'b0;
			addr_q      <= '0;
			hi_q        <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			fits_q      <= 1'b0;
			set_done_q  <= 1'b0;
		end else begin
			// drop the result once taken
			if (out_ready && state_q != icau_pkg::ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				icau_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == icau_pkg::LOC_W'(icau_pkg::LOCATIONS - 1)) begin
						state_q <= icau_pkg::ST_IDLE;
					end
				end
				icau_pkg::ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_acc) begin
						addr_q  <= icau_pkg::CNT_W'(lo_cmp);
						hi_q    <= trip_empty ? icau_pkg::CNT_W'(lo_cmp) :
						           icau_pkg::CNT_W'(hi_cmp);
						state_q <= icau_pkg::ST_WALK;
					end
				end
				icau_pkg::ST_WALK: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						addr_q <= addr_q + 1'b1;
					end
					// stop the walk at the first overflow
					if (over) begin
						ovf_q <= 1'b1;
						hi_q  <= addr_q;
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= icau_pkg::ST_FINISH;
					end
				end
				icau_pkg::ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						fits_q      <= !ovf_q;
						set_done_q  <= last_q;
						if (last_q) begin
							ovf_q   <= 1'b0;
							clr_q   <= '0;
							state_q <= icau_pkg::ST_CLEAR;
						end else begin
							state_q <= icau_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= icau_pkg::ST_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

endmodule

### src/icau_checker.sv
// Port-level checker of the interval capacity admission unit and its bind.
`timescale 1ns / 1ps

module icau_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            fits,
	input logic                            set_done
);

	logic       in_acc;
	logic       out_acc;
	logic       failed_q;
	logic [1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// track a failure reported inside an open set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= 1'b0;
		end else if (out_acc) begin
			failed_q <= !fits && !set_done;
		end
	end

	// count transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	// a failed set never recovers before it closes
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed_q |-> !fits)
		else $error("fits rose again inside a failed set");

	// one trip at a time: input closes right after a transaction
	a_one_trip: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted while a trip is in progress");

	// at most one trip in work plus one waiting result
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2 && !(pending_q == 2'd0 && out_valid))
		else $error("results and trips out of balance");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fits) && $stable(set_done))
		else $error("result changed while stalled");

endmodule

bind interval_capacity_admission_unit icau_checker u_icau_checker (.*);

### verif/interval_capacity_admission_unit_tb.sv
// Self-checking testbench for the interval capacity admission unit.
`timescale 1ns / 1ps

module interval_capacity_admission_unit_tb;

	typedef struct packed {
		logic fits;
		logic set_done;
	} verdict_t;

	logic                          clk;
	logic                          arst_n       = 1'b1;
	logic                          cfg_valid    = 1'b0;
	logic                          cfg_ready;
	logic [icau_pkg::CAP_W-1:0]    cfg_capacity = '0;
	logic                          in_valid     = 1'b0;
	logic                          in_ready;
	logic [icau_pkg::PAX_W-1:0]    passengers   = '0;
	logic [icau_pkg::SLOC_W-1:0]   start_loc    = '0;
	logic [icau_pkg::ELOC_W-1:0]   end_loc      = '0;
	logic                          last_trip    = 1'b0;
	logic                          out_valid;
	logic                          out_ready    = 1'b0;
	logic                          fits;
	logic                          set_done;

	// Shadow of the block state, advanced once per accepted trip
	logic [icau_pkg::OCC_W-1:0]    occ_shadow [icau_pkg::LOCATIONS];
	logic                          set_failed;
	logic [icau_pkg::CAP_W-1:0]    cap_shadow;

	verdict_t verdict_q [$];

	int  mismatches  = 0;
	int  trips_sent  = 0;
	int  sets_closed = 0;
	int  sets_failed = 0;
	int  cap_writes  = 0;
	bit  trip_held   = 1'b0;
	bit  free_run    = 1'b0;

	interval_capacity_admission_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_capacity (cfg_capacity),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.passengers   (passengers),
		.start_loc    (start_loc),
		.end_loc      (end_loc),
		.last_trip    (last_trip),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fits         (fits),
		.set_done     (set_done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Idle length: mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Empty the occupancy shadow and the sticky failure
	function automatic void clear_shadow();
		foreach (occ_shadow[i])
			occ_shadow[i] = '0;
		set_failed = 1'b0;
	endfunction

	// Walk the trip range, add passengers, raise the failure on the first overflow
	function automatic verdict_t admit_trip(input logic [icau_pkg::PAX_W-1:0] pax,
			input logic [icau_pkg::SLOC_W-1:0] lo, input logic [icau_pkg::ELOC_W-1:0] hi,
			input logic last);
		verdict_t v;
		int loc;
		int stop;
		logic [icau_pkg::OCC_W:0] sum;
		stop = (hi > icau_pkg::LOCATIONS) ? icau_pkg::LOCATIONS : int'(hi);
		if (!set_failed) begin
			for (loc = int'(lo); loc < stop; loc++) begin
				sum = (icau_pkg::OCC_W + 1)'(occ_shadow[loc]) +
				      (icau_pkg::OCC_W + 1)'(pax);
				if (sum > icau_pkg::OCC_MAX)
					sum = (icau_pkg::OCC_W + 1)'(icau_pkg::OCC_MAX);
				occ_shadow[loc] = sum[icau_pkg::OCC_W-1:0];
				if (sum > cap_shadow) begin
					set_failed = 1'b1;
					break;
				end
			end
		end
		v.fits     = ~set_failed;
		v.set_done = last;
		if (last) begin
			sets_closed++;
			if (set_failed)
				sets_failed++;
			clear_shadow();
		end
		return v;
	endfunction

	// Result sink: random backpressure unless free running
	initial begin : sink_ready
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (free_run) begin
				out_ready <= 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else begin
				out_ready <= ($urandom_range(0, 2) != 0);
				hold = gap_len();
			end
		end
	end

	// Compare each verdict transaction with the oldest expectation
	always @(posedge clk) begin : check_verdicts
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("verdict with no trip pending");
			end else begin
				want = verdict_q.pop_front();
				if (fits !== want.fits)
					report_mismatch($sformatf("fits %b, expected %b", fits, want.fits));
				if (set_done !== want.set_done)
					report_mismatch($sformatf("set_done %b, expected %b",
						set_done, want.set_done));
			end
		end
	end

	// Offer one trip, hold it until accepted, then idle for a random gap that may be empty
	task automatic send_trip(input int pax, input int lo, input int hi, input bit last);
		int gap;
		in_valid   <= 1'b1;
		passengers <= pax[icau_pkg::PAX_W-1:0];
		start_loc  <= lo[icau_pkg::SLOC_W-1:0];
		end_loc    <= hi[icau_pkg::ELOC_W-1:0];
		last_trip  <= last;
		do
			@(posedge clk);
		while (!in_ready);
		verdict_q.push_back(admit_trip(pax[icau_pkg::PAX_W-1:0],
			lo[icau_pkg::SLOC_W-1:0], hi[icau_pkg::ELOC_W-1:0], last));
		trips_sent++;
		gap = free_run ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			trip_held = 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			trip_held = 1'b1;
		end
	endtask

	// Drop the trip channel and wait for every outstanding verdict
	task automatic wait_verdicts();
		if (trip_held) begin
			in_valid <= 1'b0;
			trip_held = 1'b0;
		end
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input int value);
		cfg_valid    <= 1'b1;
		cfg_capacity <= value[icau_pkg::CAP_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cap_shadow = value[icau_pkg::CAP_W-1:0];
		cap_writes++;
		cfg_valid <= 1'b0;
	endtask

	// Reset capacity of zero: only empty additions fit
	task automatic test_reset_capacity();
		send_trip(0, 0, 1, 1'b0);
		send_trip(7, 900, 3, 1'b0);
		send_trip(1, 5, 6, 1'b0);
		send_trip(255, 0, 1024, 1'b1);
	endtask

	// Largest capacity, full-range, last-location, reversed and empty trips
	task automatic test_range_extremes();
		wait_verdicts();
		write_capacity(1048575);
		send_trip(255, 0, 1024, 1'b0);
		send_trip(255, 1023, 1024, 1'b0);
		send_trip(200, 1023, 0, 1'b0);
		send_trip(9, 500, 500, 1'b0);
		send_trip(255, 0, 1024, 1'b1);
	endtask

	// Fill exactly to capacity, step over it, then check trips after failure
	task automatic test_capacity_boundary();
		wait_verdicts();
		write_capacity(510);
		send_trip(255, 10, 20, 1'b0);
		send_trip(255, 10, 20, 1'b0);
		send_trip(1, 15, 16, 1'b0);
		send_trip(0, 0, 1024, 1'b0);
		send_trip(3, 0, 2, 1'b1);
		send_trip(255, 10, 20, 1'b1);
	endtask

	// Lower capacity between trips of one set
	task automatic test_capacity_mid_set();
		wait_verdicts();
		write_capacity(300);
		send_trip(200, 0, 4, 1'b0);
		wait_verdicts();
		write_capacity(150);
		send_trip(0, 8, 9, 1'b0);
		send_trip(100, 0, 1, 1'b0);
		send_trip(5, 1, 2, 1'b1);
	endtask

	// Random sets of overlapping trips in a local window, with noise and long trips
	task automatic test_random_sets(input int n_trips);
		int base;
		int n_set;
		int lo;
		int hi;
		int pax;
		int r;
		int mid_at;
		while (trips_sent < n_trips) begin
			if ($urandom_range(0, 2) == 0) begin
				wait_verdicts();
				r = $urandom_range(0, 7);
				if (r == 0)
					write_capacity(0);
				else if (r == 1)
					write_capacity(1048575);
				else if (r < 6)
					write_capacity($urandom_range(0, 1500));
				else
					write_capacity($urandom_range(0, 1048575));
			end
			free_run = ($urandom_range(0, 4) == 0);
			base     = $urandom_range(0, 1023);
			n_set    = $urandom_range(1, 12);
			mid_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n_set) : n_set;
			for (int k = 0; k < n_set; k++) begin
				// hold off the sender and retune capacity inside the set
				if (k == mid_at && k != 0) begin
					wait_verdicts();
					write_capacity($urandom_range(0, 1500));
				end
				lo = (base + $urandom_range(0, 31)) % 1024;
				r  = $urandom_range(0, 99);
				if (r < 80) begin
					hi = lo + $urandom_range(1, 24);
					if (hi > 1024)
						hi = 1024;
				end else if (r < 92) begin
					hi = $urandom_range(0, lo);
				end else if (r < 97) begin
					hi = 1024;
				end else begin
					lo = $urandom_range(0, 15);
					hi = 1024 - $urandom_range(0, 3);
				end
				r = $urandom_range(0, 99);
				if (r < 10)
					pax = 0;
				else if (r < 20)
					pax = 255;
				else
					pax = $urandom_range(0, 255);
				send_trip(pax, lo, hi, k == n_set - 1);
			end
		end
		free_run = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		clear_shadow();
		cap_shadow = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_capacity();
		test_range_extremes();
		test_capacity_boundary();
		test_capacity_mid_set();
		test_random_sets(580);

		// drain, then leave room for a clearing pass and any stray verdict
		wait_verdicts();
		repeat (1100) @(posedge clk);
		if (verdict_q.size() != 0)
			report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));

		$display("Covered %0d trips in %0d closed sets, %0d of them rejected,",
			trips_sent, sets_closed, sets_failed);
		$display("with %0d capacity writes including zero and full scale.", cap_writes);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
